@@ rtl/obb_pkg.sv @@
// ----------------------------------------------------------------------------
// obb_pkg: shared types and constants of the oriented-box overlap test
// Coordinate widths, slot layout, controller states and the command and
// status words passed between controller and datapath.
// ----------------------------------------------------------------------------
package obb_pkg;

  // coordinate and arithmetic widths
  localparam int COORD_WIDTH = 16;
  localparam int FIELD_WIDTH = 16;
  localparam int AXIS_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = COORD_WIDTH + AXIS_WIDTH;
  localparam int PROJ_WIDTH  = 2 * COORD_WIDTH + 2;

  // corner store layout
  localparam int NUM_CORNERS = 4;
  localparam int NUM_SLOTS   = 2 * NUM_CORNERS;
  localparam int SLOT_AW     = $clog2(NUM_SLOTS);
  localparam int NUM_AXES    = 4;
  localparam int AXIS_SW     = $clog2(NUM_AXES);

  localparam logic [1:0]         C_BASE    = 2'd0;
  localparam logic [1:0]         C_EDGE_A  = 2'd1;
  localparam logic [1:0]         C_EDGE_B  = 2'd3;
  localparam logic               BOX_LAST  = 1'b1;
  localparam logic [SLOT_AW-1:0] SLOT_LAST = SLOT_AW'(NUM_SLOTS - 1);
  localparam logic [AXIS_SW-1:0] AXIS_LAST = AXIS_SW'(NUM_AXES - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_AX_RD,
    S_AX_WR,
    S_DEGEN,
    S_P_RD,
    S_P_MX,
    S_P_MY,
    S_P_ACC,
    S_P_CMP,
    S_DONE
  } obb_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_BASE,
    OP_AXIS,
    OP_MULX,
    OP_MULY,
    OP_ACC,
    OP_SEP,
    OP_CLR
  } obb_op_t;

  typedef struct packed {
    logic               wr_en;
    logic               rd_en;
    logic [SLOT_AW-1:0] rd_addr;
    obb_op_t            op;
    logic [AXIS_SW-1:0] axis_sel;
    logic               first;
    logic               box;
    logic               load_out;
  } obb_cmd_t;

  typedef struct packed {
    logic degen;
    logic result;
  } obb_sts_t;

endpackage

@@ rtl/obb_ram.sv @@
// ----------------------------------------------------------------------------
// obb_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data held while the
// read enable is low.
// ----------------------------------------------------------------------------
module obb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/obb_ctrl.sv @@
// ----------------------------------------------------------------------------
// obb_ctrl: sequencer of the overlap test
// Takes corner words, then steps the datapath through axis setup, four
// projections per box on each axis, and the final result hand-off.
// ----------------------------------------------------------------------------
module obb_ctrl
  import obb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_box_id,
  input  logic [1:0] in_corner,
  output logic     out_valid,
  input  logic     out_ready,
  input  obb_sts_t sts,
  output obb_cmd_t cmd
);

  obb_state_t         state_r, state_nxt;
  logic [SLOT_AW-1:0] idx_r, idx_nxt;
  logic [AXIS_SW-1:0] axis_r, axis_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               accept;
  logic               out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (accept && in_box_id == BOX_LAST && in_corner == C_EDGE_B) begin
          state_nxt = S_AX_RD;
          idx_nxt   = '0;
          axis_nxt  = '0;
        end
      end
      S_AX_RD: begin
        state_nxt = S_AX_WR;
      end
      S_AX_WR: begin
        if (idx_r == SLOT_LAST) begin
          state_nxt = S_DEGEN;
          idx_nxt   = '0;
        end else begin
          state_nxt = S_AX_RD;
          // slots with corner 2 are not needed for the axes
          idx_nxt   = (idx_r[1:0] == C_EDGE_A) ? idx_r + SLOT_AW'(2) : idx_r + SLOT_AW'(1);
        end
      end
      S_DEGEN: begin
        state_nxt = sts.degen ? S_DONE : S_P_RD;
      end
      S_P_RD: begin
        state_nxt = S_P_MX;
      end
      S_P_MX: begin
        state_nxt = S_P_MY;
      end
      S_P_MY: begin
        state_nxt = S_P_ACC;
      end
      S_P_ACC: begin
        if (idx_r == SLOT_LAST) begin
          state_nxt = S_P_CMP;
          idx_nxt   = '0;
        end else begin
          state_nxt = S_P_RD;
          idx_nxt   = idx_r + SLOT_AW'(1);
        end
      end
      S_P_CMP: begin
        if (axis_r == AXIS_LAST) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_P_RD;
          axis_nxt  = axis_r + AXIS_SW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.wr_en    = accept;
    cmd.rd_addr  = idx_r;
    cmd.axis_sel = axis_r;
    cmd.box      = idx_r[SLOT_AW-1];
    cmd.first    = (idx_r[1:0] == C_BASE);
    case (state_r)
      S_AX_RD: begin
        cmd.rd_en = 1'b1;
      end
      S_AX_WR: begin
        case (idx_r[1:0])
          C_BASE: begin
            cmd.op = OP_BASE;
          end
          C_EDGE_A: begin
            cmd.op       = OP_AXIS;
            cmd.axis_sel = {idx_r[SLOT_AW-1], 1'b0};
          end
          C_EDGE_B: begin
            cmd.op       = OP_AXIS;
            cmd.axis_sel = {idx_r[SLOT_AW-1], 1'b1};
          end
          default: begin
            cmd.op = OP_NONE;
          end
        endcase
      end
      S_DEGEN: begin
        cmd.op = OP_CLR;
      end
      S_P_RD: begin
        cmd.rd_en = 1'b1;
      end
      S_P_MX: begin
        cmd.op = OP_MULX;
      end
      S_P_MY: begin
        cmd.op = OP_MULY;
      end
      S_P_ACC: begin
        cmd.op = OP_ACC;
      end
      S_P_CMP: begin
        cmd.op = OP_SEP;
      end
      S_DONE: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd.op = OP_NONE;
      end
    endcase
  end

endmodule

@@ rtl/obb_dp.sv @@
// ----------------------------------------------------------------------------
// obb_dp: datapath of the overlap test
// Corner store, edge-vector axes, one shared multiplier, per-box min/max
// tracking of projections and the result register.
// ----------------------------------------------------------------------------
module obb_dp
  import obb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_box_id,
  input  logic [1:0]             in_corner,
  input  logic [FIELD_WIDTH-1:0] in_coord_x,
  input  logic [FIELD_WIDTH-1:0] in_coord_y,
  input  obb_cmd_t               cmd,
  output obb_sts_t               sts,
  output logic                   out_colliding
);

  localparam int RAW_WIDTH = COORD_WIDTH + FIELD_WIDTH;

  logic [RAW_WIDTH-1:0]         raw_x, raw_y;
  logic [2*COORD_WIDTH-1:0]     wr_data, rd_data;
  logic signed [COORD_WIDTH-1:0] rx, ry;

  logic signed [COORD_WIDTH-1:0] base_x_r, base_y_r;
  logic signed [AXIS_WIDTH-1:0]  axx_r [NUM_AXES];
  logic signed [AXIS_WIDTH-1:0]  axy_r [NUM_AXES];
  logic signed [PROD_WIDTH-1:0]  prod_r, part_r;
  logic signed [PROJ_WIDTH-1:0]  min0_r, max0_r, min1_r, max1_r;
  logic signed [PROJ_WIDTH-1:0]  proj;
  logic                          sep_r;
  logic                          colliding_r;
  logic                          degen;

  // keep the low COORD_WIDTH bits of each field
  assign raw_x   = {{COORD_WIDTH{1'b0}}, in_coord_x};
  assign raw_y   = {{COORD_WIDTH{1'b0}}, in_coord_y};
  assign wr_data = {raw_y[COORD_WIDTH-1:0], raw_x[COORD_WIDTH-1:0]};

  obb_ram #(
    .WIDTH (2 * COORD_WIDTH),
    .DEPTH (NUM_SLOTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr ({in_box_id, in_corner}),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.rd_addr),
    .rd_data (rd_data)
  );

  assign rx = $signed(rd_data[COORD_WIDTH-1:0]);
  assign ry = $signed(rd_data[2*COORD_WIDTH-1:COORD_WIDTH]);

  // projection of the current corner
  assign proj = PROJ_WIDTH'(part_r) + PROJ_WIDTH'(prod_r);

  // zero width or height of the first box
  assign degen = (axx_r[0] == '0 && axy_r[0] == '0) ||
                 (axx_r[1] == '0 && axy_r[1] == '0);

  // axis setup
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_BASE: begin
        base_x_r <= rx;
        base_y_r <= ry;
      end
      OP_AXIS: begin
        axx_r[cmd.axis_sel] <= AXIS_WIDTH'(rx) - AXIS_WIDTH'(base_x_r);
        axy_r[cmd.axis_sel] <= AXIS_WIDTH'(ry) - AXIS_WIDTH'(base_y_r);
      end
      default: begin
      end
    endcase
  end

  // shared multiplier, x term then y term
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_MULX: begin
        prod_r <= PROD_WIDTH'(rx) * PROD_WIDTH'(axx_r[cmd.axis_sel]);
      end
      OP_MULY: begin
        part_r <= prod_r;
        prod_r <= PROD_WIDTH'(ry) * PROD_WIDTH'(axy_r[cmd.axis_sel]);
      end
      default: begin
      end
    endcase
  end

  // per-box projection extent
  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACC) begin
      if (!cmd.box) begin
        if (cmd.first || proj < min0_r) min0_r <= proj;
        if (cmd.first || proj > max0_r) max0_r <= proj;
      end else begin
        if (cmd.first || proj < min1_r) min1_r <= proj;
        if (cmd.first || proj > max1_r) max1_r <= proj;
      end
    end
  end

  // separation flag and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= 1'b0;
    end else if (cmd.op == OP_CLR) begin
      sep_r <= 1'b0;
    end else if (cmd.op == OP_SEP) begin
      sep_r <= sep_r || (max0_r < min1_r) || (max1_r < min0_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      colliding_r <= sts.result;
    end
  end

  assign sts.degen     = degen;
  assign sts.result    = !degen && !sep_r;
  assign out_colliding = colliding_r;

endmodule

@@ rtl/obb_overlap_sat_test.sv @@
// ----------------------------------------------------------------------------
// obb_overlap_sat_test: separating-axis overlap test of two oriented boxes
// Corner words are stored one by one; the last corner of the second box
// starts the test, which produces one result word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one corner word per transfer, with
//   box id, corner index and signed x/y in 1/16 pixel. The word is written
//   to the corner store in the cycle it is accepted.
//   Only corner 3 of box 1 produces a result; all other words produce none
//   and leave in_ready high.
//   Output channel (out_valid/out_ready): one word, colliding, per test.
//   Sequence: once the final corner is accepted the test runs axis setup,
//   a degenerate check, then each of the 4 axes (all 8 corners read, with
//   x and y terms through the one shared multiplier and accumulated, then
//   a compare), then loads the result; a degenerate first box skips the
//   axes. in_ready is low during the test.
//   The result sits in an output register; corner words are taken while it
//   waits. A test that finishes while the previous result is still stalled
//   holds until that result is taken.
//   Reset clears the controller and the output valid; the corner store
//   holds no defined data until written.
// ----------------------------------------------------------------------------
module obb_overlap_sat_test
  import obb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_box_id,
  input  logic [1:0]             in_corner,
  input  logic [FIELD_WIDTH-1:0] in_coord_x,
  input  logic [FIELD_WIDTH-1:0] in_coord_y,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_colliding
);

  obb_cmd_t cmd;
  obb_sts_t sts;

  // sequencer
  obb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_box_id (in_box_id),
    .in_corner (in_corner),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and storage
  obb_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_box_id     (in_box_id),
    .in_corner     (in_corner),
    .in_coord_x    (in_coord_x),
    .in_coord_y    (in_coord_y),
    .cmd           (cmd),
    .sts           (sts),
    .out_colliding (out_colliding)
  );

endmodule

@@ verif/tb_obb_overlap_sat_test.sv @@
// ----------------------------------------------------------------------------
// tb_obb_overlap_sat_test: self-checking bench for the oriented-box SAT test
// Feeds corner words of box pairs through the input channel and checks every
// colliding word against a behavioral overlap predictor. A short directed set
// covers overlap, degenerate boxes and extreme coordinates. Random box pairs,
// touching boxes, raw noise and partial updates follow. Both channels see
// random idle bursts. A result with nothing waiting, a wrong field and a
// hang all count as failures.
// ----------------------------------------------------------------------------
module tb_obb_overlap_sat_test;
  import obb_pkg::*;

  localparam int ITEM_TARGET = 1650;
  localparam int CALM_ITEMS  = 160;
  localparam int QUEUE_DEPTH = 24;
  localparam int TAIL_CYCLES = 200;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic                   box;
    logic [1:0]             crn;
    logic [FIELD_WIDTH-1:0] x;
    logic [FIELD_WIDTH-1:0] y;
  } corner_word_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_box_id = 1'b0;
  logic [1:0]             in_corner = '0;
  logic [FIELD_WIDTH-1:0] in_coord_x = '0;
  logic [FIELD_WIDTH-1:0] in_coord_y = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_colliding;

  corner_word_t corner_words[$];
  bit           pending_verdicts[$];
  longint       corner_x[NUM_SLOTS];
  longint       corner_y[NUM_SLOTS];
  bit           in_taken;
  int           mismatches;
  int           words_queued;
  int           in_gap_pct;
  int           out_stall_pct;
  int           gap_left;
  int           stall_left;

  obb_overlap_sat_test i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_box_id    (in_box_id),
    .in_corner    (in_corner),
    .in_coord_x   (in_coord_x),
    .in_coord_y   (in_coord_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_colliding(out_colliding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // overlap predictor over the stored corners, unnormalized edge axes
  function automatic bit sat_collide();
    longint ax[NUM_AXES];
    longint ay[NUM_AXES];
    longint lo0, hi0, lo1, hi1, q0, q1;
    for (int b = 0; b < 2; b++) begin
      ax[2*b]   = corner_x[b*NUM_CORNERS + C_EDGE_A] - corner_x[b*NUM_CORNERS + C_BASE];
      ay[2*b]   = corner_y[b*NUM_CORNERS + C_EDGE_A] - corner_y[b*NUM_CORNERS + C_BASE];
      ax[2*b+1] = corner_x[b*NUM_CORNERS + C_EDGE_B] - corner_x[b*NUM_CORNERS + C_BASE];
      ay[2*b+1] = corner_y[b*NUM_CORNERS + C_EDGE_B] - corner_y[b*NUM_CORNERS + C_BASE];
    end
    // zero width or height of the first box never collides
    if ((ax[0] == 0 && ay[0] == 0) || (ax[1] == 0 && ay[1] == 0))
      return 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      lo0 = corner_x[0] * ax[a] + corner_y[0] * ay[a];
      hi0 = lo0;
      lo1 = corner_x[NUM_CORNERS] * ax[a] + corner_y[NUM_CORNERS] * ay[a];
      hi1 = lo1;
      for (int i = 1; i < NUM_CORNERS; i++) begin
        q0 = corner_x[i] * ax[a] + corner_y[i] * ay[a];
        q1 = corner_x[NUM_CORNERS+i] * ax[a] + corner_y[NUM_CORNERS+i] * ay[a];
        if (q0 < lo0) lo0 = q0;
        if (q0 > hi0) hi0 = q0;
        if (q1 < lo1) lo1 = q1;
        if (q1 > hi1) hi1 = q1;
      end
      if (hi0 < lo1 || hi1 < lo0)
        return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic int spread(input int mag);
    return int'($urandom_range(0, 2 * mag)) - mag;
  endfunction

  // queue one corner word; keep the queue shallow so idle settings track it
  task automatic push_word(input bit box, input int crn, input int x, input int y);
    corner_word_t w;
    while (corner_words.size() >= QUEUE_DEPTH) @(posedge clk);
    w.box = box;
    w.crn = crn[1:0];
    w.x   = x[FIELD_WIDTH-1:0];
    w.y   = y[FIELD_WIDTH-1:0];
    corner_words.push_back(w);
    words_queued++;
  endtask

  // parallelogram: p0, p0+e, p0+e+f, p0+f in winding order
  task automatic push_quad(input bit box, input int x0, input int y0,
                           input int ex, input int ey, input int fx, input int fy);
    push_word(box, 0, x0, y0);
    push_word(box, 1, x0 + ex, y0 + ey);
    push_word(box, 2, x0 + ex + fx, y0 + ey + fy);
    push_word(box, 3, x0 + fx, y0 + fy);
  endtask

  // hold the sender until every queued word is in and every result is out
  task automatic drain_results();
    while (corner_words.size() != 0 || in_valid || pending_verdicts.size() != 0)
      @(posedge clk);
  endtask

  // monitor: store accepted corners, check result words
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result word with none expected, colliding=%b",
                                  out_colliding));
      end else begin
        if (out_colliding !== pending_verdicts[0])
          report_mismatch($sformatf("colliding got %b expected %b",
                                    out_colliding, pending_verdicts[0]));
        void'(pending_verdicts.pop_front());
      end
    end
    if (in_taken) begin
      corner_x[{in_box_id, in_corner}] = longint'($signed(in_coord_x[COORD_WIDTH-1:0]));
      corner_y[{in_box_id, in_corner}] = longint'($signed(in_coord_y[COORD_WIDTH-1:0]));
      if (in_box_id == BOX_LAST && in_corner == C_EDGE_B)
        pending_verdicts.push_back(sat_collide());
    end
  end

  // input driver
  always @(negedge clk) begin
    corner_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (corner_words.size() != 0) begin
        w = corner_words.pop_front();
        in_valid   <= 1'b1;
        in_box_id  <= w.box;
        in_corner  <= w.crn;
        in_coord_x <= w.x;
        in_coord_y <= w.y;
        if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct)
          gap_left = $urandom_range(1, 10);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver with stall bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct)
        stall_left = $urandom_range(1, 10);
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int kind, mag, mag2, m, x0, y0, ex, ey, fx, fy, w, h, d, n, b, c, tests;
    in_gap_pct    = 0;
    out_stall_pct = 0;
    tests         = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: overlapping unit squares fill every slot first
    push_quad(0, 0, 0, 16, 0, 0, 16);
    push_quad(1, 8, 8, 16, 0, 0, 16);
    // zero-width first box
    push_word(0, 1, 0, 0);
    push_word(1, 3, 8, 24);
    // zero-height first box
    push_word(0, 1, 16, 0);
    push_word(0, 3, 0, 0);
    push_word(1, 3, 8, 24);
    // second box collapsed to a point inside the first
    push_word(0, 3, 0, 16);
    push_quad(1, 4, 4, 0, 0, 0, 0);
    // full-range coordinates on both boxes
    push_quad(0, -32768, -32768, 65535, 0, 0, 65535);
    push_quad(1, 32767, 32767, -65535, 0, 0, -65535);
    drain_results();

    while (words_queued < ITEM_TARGET) begin
      if (words_queued >= ITEM_TARGET - CALM_ITEMS) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else if (tests % 8 == 0) begin
        case ($urandom_range(0, 3))
          0: in_gap_pct = 0;
          1: in_gap_pct = 5;
          2: in_gap_pct = 20;
          default: in_gap_pct = 50;
        endcase
        case ($urandom_range(0, 3))
          0: out_stall_pct = 0;
          1: out_stall_pct = 10;
          2: out_stall_pct = 40;
          default: out_stall_pct = 80;
        endcase
      end
      tests++;
      kind = $urandom_range(0, 99);
      x0 = spread(8000);
      y0 = spread(8000);
      if (kind < 45) begin
        // rotated rectangles near each other
        mag = 1 << $urandom_range(2, 11);
        ex = spread(mag);
        ey = spread(mag);
        m  = $urandom_range(1, 16);
        push_quad(0, x0, y0, ex, ey, -ey * m / 8, ex * m / 8);
        mag2 = 1 << $urandom_range(2, 11);
        ex = spread(mag2);
        ey = spread(mag2);
        m  = $urandom_range(1, 16);
        push_quad(1, x0 + spread(3 * mag), y0 + spread(3 * mag), ex, ey,
                  -ey * m / 8, ex * m / 8);
      end else if (kind < 60) begin
        // axis-aligned boxes that touch, nearly touch or just overlap
        w = $urandom_range(1, 2000);
        h = $urandom_range(1, 2000);
        d = spread(1);
        push_quad(0, x0, y0, w, 0, 0, h);
        if ($urandom_range(0, 1))
          push_quad(1, x0 + w + d, y0 + spread(h), $urandom_range(1, 2000), 0,
                    0, $urandom_range(1, 2000));
        else
          push_quad(1, x0 + spread(w), y0 - d - $urandom_range(0, 0) - h, w, 0,
                    0, h);
      end else if (kind < 70) begin
        // first box with a zero edge
        mag = 1 << $urandom_range(2, 11);
        ex = spread(mag);
        ey = spread(mag);
        if ($urandom_range(0, 1))
          push_quad(0, x0, y0, 0, 0, ex, ey);
        else
          push_quad(0, x0, y0, ex, ey, 0, 0);
        push_quad(1, x0, y0, ey, ex, ex, -ey);
      end else if (kind < 75) begin
        // second box with a zero axis or collapsed to a point
        mag = 1 << $urandom_range(2, 11);
        ex = spread(mag);
        ey = spread(mag);
        push_quad(0, x0, y0, ex, ey, -ey, ex);
        fx = spread(2 * mag);
        fy = spread(2 * mag);
        case ($urandom_range(0, 2))
          0: push_quad(1, x0 + fx, y0 + fy, 0, 0, 0, 0);
          1: push_quad(1, x0 + fx, y0 + fy, 0, 0, ey, ex);
          default: push_quad(1, x0 + fx, y0 + fy, ey, ex, 0, 0);
        endcase
      end else if (kind < 85) begin
        // raw full-range corners
        for (int i = 0; i < NUM_SLOTS; i++)
          push_word(i / NUM_CORNERS, i % NUM_CORNERS, int'($urandom), int'($urandom));
      end else if (kind < 93) begin
        // partial update in arbitrary order, then the trigger word
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          b = $urandom_range(0, 1);
          c = (b == BOX_LAST) ? $urandom_range(0, 2) : $urandom_range(0, 3);
          push_word(b, c, spread(4000), spread(4000));
        end
        push_word(BOX_LAST, C_EDGE_B, spread(4000), spread(4000));
      end else begin
        // stray words with no result
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          b = $urandom_range(0, 1);
          c = (b == BOX_LAST) ? $urandom_range(0, 2) : $urandom_range(0, 3);
          push_word(b, c, int'($urandom), int'($urandom));
        end
      end
      if ($urandom_range(0, 49) == 0)
        drain_results();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
